FILE: rtl/tpt_pkg.sv
// tpt_pkg: shared types, codes and helpers of the touch point tracker
// used by tpt_cfg, tpt_ctrl, tpt_datapath and touch_point_tracker_unit
`default_nettype none

package tpt_pkg;

    // touch phase codes
    localparam logic [2:0] PH_NONE     = 3'd0;
    localparam logic [2:0] PH_PRESSED  = 3'd1;
    localparam logic [2:0] PH_MOVED    = 3'd2;
    localparam logic [2:0] PH_HELD     = 3'd3;
    localparam logic [2:0] PH_RELEASED = 3'd4;

    // rotation codes, quarter turns
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ROTATION     = 3'd0;
    localparam logic [2:0] REG_PANEL_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PANEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_DEAD_ZONE    = 3'd3;
    localparam logic [2:0] REG_SMOOTH_ZONE  = 3'd4;

    localparam logic [12:0] PANEL_MAX = 13'd4096;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [12:0] width;     // panel width limited to 1..4096
        logic [12:0] height;    // panel height limited to 1..4096
        logic [11:0] dead_zone;
        logic [12:0] smooth_zone;
    } cfg_t;

    typedef struct packed {
        logic load_frame;
        logic do_match;
        logic do_diff;
        logic do_update;
        logic do_release;
        logic do_count;
        logic emit_load;
        logic pt_sel;
    } cmd_t;

    typedef struct packed {
        logic pt_live;
        logic hit_found;
        logic out_free;
    } status_t;

    // mirrored coordinate lim-1-v, zero where v lies at or beyond lim
    function automatic logic [11:0] mirror(input logic [12:0] lim, input logic [11:0] v);
        logic [12:0] diff;
        diff = lim - 13'd1 - {1'b0, v};
        if ({1'b0, v} >= lim) begin
            mirror = 12'd0;
        end else begin
            mirror = diff[11:0];
        end
    endfunction

    function automatic logic [12:0] eff_size(input logic [12:0] v);
        if (v == 13'd0) begin
            eff_size = 13'd1;
        end else if (v > PANEL_MAX) begin
            eff_size = PANEL_MAX;
        end else begin
            eff_size = v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tpt_cfg.sv
// tpt_cfg: configuration registers of the touch point tracker
// depends on tpt_pkg for register indexes and the cfg_t bundle
`default_nettype none

module tpt_cfg (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [12:0]  cfg_data,
    output tpt_pkg::cfg_t     cfg
);

    logic [1:0]  rotation_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] dead_reg;
    logic [12:0] smooth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= 2'd0;
            width_reg    <= 13'd320;
            height_reg   <= 13'd480;
            dead_reg     <= 12'd2;
            smooth_reg   <= 13'd12;
        end else if (cfg_valid) begin
            case (cfg_index)
                tpt_pkg::REG_ROTATION:     rotation_reg <= cfg_data[1:0];
                tpt_pkg::REG_PANEL_WIDTH:  width_reg    <= cfg_data;
                tpt_pkg::REG_PANEL_HEIGHT: height_reg   <= cfg_data;
                tpt_pkg::REG_DEAD_ZONE:    dead_reg     <= cfg_data[11:0];
                tpt_pkg::REG_SMOOTH_ZONE:  smooth_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.rotation    = rotation_reg;
        cfg.width       = tpt_pkg::eff_size(width_reg);
        cfg.height      = tpt_pkg::eff_size(height_reg);
        cfg.dead_zone   = dead_reg;
        cfg.smooth_zone = smooth_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/tpt_ctrl.sv
// tpt_ctrl: frame sequencer of the touch point tracker
// depends on tpt_pkg for cmd_t and status_t; drives tpt_datapath
`default_nettype none

module tpt_ctrl #(
    parameter int SLOTS = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tpt_pkg::status_t     status,
    output tpt_pkg::cmd_t             cmd,
    output logic [$clog2(SLOTS)-1:0]  out_idx
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MATCH   = 3'd1;
    localparam logic [2:0] S_DIFF    = 3'd2;
    localparam logic [2:0] S_UPDATE  = 3'd3;
    localparam logic [2:0] S_RELEASE = 3'd4;
    localparam logic [2:0] S_COUNT   = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          pt_reg, pt_next;
    logic [SW-1:0] idx_reg, idx_next;

    assign s_ready = (state_reg == S_IDLE);
    assign out_idx = idx_reg;

    always_comb begin
        state_next     = state_reg;
        pt_next        = pt_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.pt_sel     = pt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_frame = 1'b1;
                    pt_next        = 1'b0;
                    state_next     = S_MATCH;
                end
            end
            S_MATCH: begin
                if (!status.pt_live) begin
                    state_next = S_RELEASE;
                end else if (status.hit_found) begin
                    cmd.do_match = 1'b1;
                    state_next   = S_DIFF;
                end else if (!pt_reg) begin
                    // point dropped, try the second one
                    pt_next = 1'b1;
                end else begin
                    state_next = S_RELEASE;
                end
            end
            S_DIFF: begin
                cmd.do_diff = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.do_update = 1'b1;
                if (!pt_reg) begin
                    pt_next    = 1'b1;
                    state_next = S_MATCH;
                end else begin
                    state_next = S_RELEASE;
                end
            end
            S_RELEASE: begin
                cmd.do_release = 1'b1;
                state_next     = S_COUNT;
            end
            S_COUNT: begin
                cmd.do_count = 1'b1;
                idx_next     = '0;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pt_reg    <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tpt_datapath.sv
// tpt_datapath: frame latch, slot state, rotate/clamp, jitter filter and result register
// depends on tpt_pkg; steered by tpt_ctrl through cmd_t / status_t
`default_nettype none

module tpt_datapath #(
    parameter int SLOTS = 2
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tpt_pkg::cfg_t              cfg,
    input  wire tpt_pkg::cmd_t              cmd,
    input  wire logic [$clog2(SLOTS)-1:0]   out_idx,
    output tpt_pkg::status_t                status,
    input  wire logic [3:0]                 s_point_count,
    input  wire logic [11:0]                s_first_x,
    input  wire logic [11:0]                s_first_y,
    input  wire logic [3:0]                 s_first_id,
    input  wire logic [11:0]                s_second_x,
    input  wire logic [11:0]                s_second_y,
    input  wire logic [3:0]                 s_second_id,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [2:0]                      m_slot_number,
    output logic [3:0]                      m_touch_id,
    output logic [11:0]                     m_pos_x,
    output logic [11:0]                     m_pos_y,
    output logic [2:0]                      m_touch_phase,
    output logic                            m_active,
    output logic [3:0]                      m_active_count,
    output logic                            m_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    // frame latch
    logic [1:0]  ncap_reg;
    logic [11:0] x_reg [2];
    logic [11:0] y_reg [2];
    logic [3:0]  id_reg [2];

    // slot state
    logic        used_reg   [SLOTS];
    logic [3:0]  tag_reg    [SLOTS];
    logic [11:0] px_reg     [SLOTS];
    logic [11:0] py_reg     [SLOTS];
    logic [2:0]  phase_reg  [SLOTS];
    logic        seen_reg   [SLOTS];
    logic        before_reg [SLOTS];

    // per-point working registers
    logic [SW-1:0] hit_reg;
    logic          fresh_reg;
    logic [11:0]   rot_x_reg, rot_y_reg;
    logic [11:0]   cx_reg, cy_reg;
    logic [11:0]   old_x_reg, old_y_reg;
    logic [11:0]   dx_reg, dy_reg;
    logic [CW-1:0] count_reg;

    logic          m_valid_reg;

    // match search and rotation
    logic [11:0]   cur_x, cur_y;
    logic [3:0]    cur_id;
    logic          tag_hit, free_hit;
    logic [SW-1:0] tag_idx, free_idx, hit_idx;
    logic [11:0]   rot_x, rot_y;

    // clamp and distance
    logic [12:0]   w_m1, h_m1;
    logic [11:0]   clamp_x, clamp_y, old_x, old_y, diff_x, diff_y;

    // filter
    logic [12:0]   man_dist, sum_x, sum_y;
    logic [11:0]   new_x, new_y;

    // active count
    logic [CW-1:0] active_sum;

    assign cur_x  = cmd.pt_sel ? x_reg[1]  : x_reg[0];
    assign cur_y  = cmd.pt_sel ? y_reg[1]  : y_reg[0];
    assign cur_id = cmd.pt_sel ? id_reg[1] : id_reg[0];

    always_comb begin
        tag_hit  = 1'b0;
        free_hit = 1'b0;
        tag_idx  = '0;
        free_idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (!tag_hit && used_reg[k] && tag_reg[k] == cur_id) begin
                tag_hit = 1'b1;
                tag_idx = SW'(k);
            end
            if (!free_hit && !used_reg[k]) begin
                free_hit = 1'b1;
                free_idx = SW'(k);
            end
        end
        hit_idx = tag_hit ? tag_idx : free_idx;
    end

    always_comb begin
        case (cfg.rotation)
            tpt_pkg::ROT_90: begin
                rot_x = cur_y;
                rot_y = tpt_pkg::mirror(cfg.height, cur_x);
            end
            tpt_pkg::ROT_180: begin
                rot_x = tpt_pkg::mirror(cfg.width, cur_x);
                rot_y = tpt_pkg::mirror(cfg.height, cur_y);
            end
            tpt_pkg::ROT_270: begin
                rot_x = tpt_pkg::mirror(cfg.width, cur_y);
                rot_y = tpt_pkg::mirror(cfg.height, cur_x);
            end
            default: begin
                rot_x = cur_x;
                rot_y = cur_y;
            end
        endcase
    end

    always_comb begin
        w_m1    = cfg.width - 13'd1;
        h_m1    = cfg.height - 13'd1;
        clamp_x = ({1'b0, rot_x_reg} >= cfg.width)  ? w_m1[11:0] : rot_x_reg;
        clamp_y = ({1'b0, rot_y_reg} >= cfg.height) ? h_m1[11:0] : rot_y_reg;
        old_x   = px_reg[hit_reg];
        old_y   = py_reg[hit_reg];
        diff_x  = (clamp_x > old_x) ? clamp_x - old_x : old_x - clamp_x;
        diff_y  = (clamp_y > old_y) ? clamp_y - old_y : old_y - clamp_y;
    end

    always_comb begin
        man_dist = {1'b0, dx_reg} + {1'b0, dy_reg};
        sum_x    = {1'b0, cx_reg} + {1'b0, old_x_reg};
        sum_y    = {1'b0, cy_reg} + {1'b0, old_y_reg};
        if (man_dist <= {1'b0, cfg.dead_zone}) begin
            new_x = old_x_reg;
            new_y = old_y_reg;
        end else if (man_dist <= cfg.smooth_zone) begin
            new_x = sum_x[12:1];
            new_y = sum_y[12:1];
        end else begin
            new_x = cx_reg;
            new_y = cy_reg;
        end
    end

    always_comb begin
        active_sum = '0;
        for (int k = 0; k < SLOTS; k++) begin
            active_sum = active_sum +
                CW'(used_reg[k] && phase_reg[k] != tpt_pkg::PH_RELEASED);
        end
    end

    always_comb begin
        status.pt_live   = ({1'b0, cmd.pt_sel} < ncap_reg);
        status.hit_found = tag_hit || free_hit;
        status.out_free  = !m_valid_reg || m_ready;
    end

    // frame latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_frame) begin
            ncap_reg  <= (s_point_count >= 4'd2) ? 2'd2 : s_point_count[1:0];
            x_reg[0]  <= s_first_x;
            y_reg[0]  <= s_first_y;
            id_reg[0] <= s_first_id;
            x_reg[1]  <= s_second_x;
            y_reg[1]  <= s_second_y;
            id_reg[1] <= s_second_id;
        end
        if (cmd.do_match) begin
            hit_reg   <= hit_idx;
            fresh_reg <= !used_reg[hit_idx];
            rot_x_reg <= rot_x;
            rot_y_reg <= rot_y;
        end
        if (cmd.do_diff) begin
            cx_reg    <= clamp_x;
            cy_reg    <= clamp_y;
            old_x_reg <= old_x;
            old_y_reg <= old_y;
            dx_reg    <= diff_x;
            dy_reg    <= diff_y;
        end
        if (cmd.do_count) begin
            count_reg <= active_sum;
        end
    end

    // slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                used_reg[k]   <= 1'b0;
                tag_reg[k]    <= 4'd0;
                px_reg[k]     <= 12'd0;
                py_reg[k]     <= 12'd0;
                phase_reg[k]  <= tpt_pkg::PH_NONE;
                seen_reg[k]   <= 1'b0;
                before_reg[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                if (cmd.load_frame) begin
                    before_reg[k] <= seen_reg[k];
                    seen_reg[k]   <= 1'b0;
                end
                if (cmd.do_update && hit_reg == SW'(k)) begin
                    seen_reg[k] <= 1'b1;
                    if (fresh_reg) begin
                        used_reg[k]  <= 1'b1;
                        tag_reg[k]   <= cmd.pt_sel ? id_reg[1] : id_reg[0];
                        px_reg[k]    <= cx_reg;
                        py_reg[k]    <= cy_reg;
                        phase_reg[k] <= tpt_pkg::PH_PRESSED;
                    end else begin
                        px_reg[k]    <= new_x;
                        py_reg[k]    <= new_y;
                        phase_reg[k] <= (new_x != old_x_reg || new_y != old_y_reg) ?
                                        tpt_pkg::PH_MOVED : tpt_pkg::PH_HELD;
                    end
                end
                if (cmd.do_release && !seen_reg[k]) begin
                    if (before_reg[k]) begin
                        phase_reg[k] <= tpt_pkg::PH_RELEASED;
                    end else if (phase_reg[k] == tpt_pkg::PH_RELEASED) begin
                        // absent a second frame: free the slot
                        used_reg[k]  <= 1'b0;
                        phase_reg[k] <= tpt_pkg::PH_NONE;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_slot_number  <= 3'(out_idx);
            m_touch_id     <= used_reg[out_idx] ? tag_reg[out_idx] : 4'd0;
            m_pos_x        <= used_reg[out_idx] ? px_reg[out_idx] : 12'd0;
            m_pos_y        <= used_reg[out_idx] ? py_reg[out_idx] : 12'd0;
            m_touch_phase  <= used_reg[out_idx] ? phase_reg[out_idx] : tpt_pkg::PH_NONE;
            m_active       <= used_reg[out_idx] &&
                              phase_reg[out_idx] != tpt_pkg::PH_RELEASED;
            m_active_count <= 4'(count_reg);
            m_last         <= (out_idx == LAST_IDX);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/touch_point_tracker_unit.sv
// touch_point_tracker_unit: top level of the multitouch point tracker with jitter filter
// instantiates tpt_cfg, tpt_ctrl and tpt_datapath; uses tpt_pkg
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      one controller frame: count, two points
//  m_        out        m_valid / m_ready      one beat per slot, slots 0..SLOTS-1
//  cfg_      in         cfg_valid / cfg_ready  register index and write data
//
// a frame is accepted in idle; each taken point passes match/rotate, clamp/distance
// and filter/write, a dropped point a single match check, and a closing check follows
// unless the count is two or more; then release, count and an emit per slot follow,
// and back in idle the next frame is accepted at once.
// the emit step waits on the output register, so m_ready low stretches it beat by beat.
// synchronous active-low reset frees all slots and loads the register defaults.
`default_nettype none

module touch_point_tracker_unit #(
    parameter int SLOTS = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [3:0]   s_point_count,
    input  wire logic [11:0]  s_first_x,
    input  wire logic [11:0]  s_first_y,
    input  wire logic [3:0]   s_first_id,
    input  wire logic [11:0]  s_second_x,
    input  wire logic [11:0]  s_second_y,
    input  wire logic [3:0]   s_second_id,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_slot_number,
    output logic [3:0]        m_touch_id,
    output logic [11:0]       m_pos_x,
    output logic [11:0]       m_pos_y,
    output logic [2:0]        m_touch_phase,
    output logic              m_active,
    output logic [3:0]        m_active_count,
    output logic              m_last,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [12:0]  cfg_data
);

    tpt_pkg::cfg_t             cfg;
    tpt_pkg::cmd_t             cmd;
    tpt_pkg::status_t          status;
    logic [$clog2(SLOTS)-1:0]  out_idx;

    tpt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .out_idx (out_idx)
    );

    tpt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .out_idx        (out_idx),
        .status         (status),
        .s_point_count  (s_point_count),
        .s_first_x      (s_first_x),
        .s_first_y      (s_first_y),
        .s_first_id     (s_first_id),
        .s_second_x     (s_second_x),
        .s_second_y     (s_second_y),
        .s_second_id    (s_second_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot_number  (m_slot_number),
        .m_touch_id     (m_touch_id),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_touch_phase  (m_touch_phase),
        .m_active       (m_active),
        .m_active_count (m_active_count),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire
